// ===== sv/framebuffer_display_with_key_fifo_defines.svh =====
// Assertion macros used by the display block's checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FRAMEBUFFER_DISPLAY_WITH_KEY_FIFO_DEFINES_SVH
`define FRAMEBUFFER_DISPLAY_WITH_KEY_FIFO_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define FBKF_CHK_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define FBKF_CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== sv/fbkf_pkg.sv =====
// Package for the framebuffer display block: constants, register map, types.
// No dependencies; imported by every module of the block.
package fbkf_pkg;

   // block geometry
   localparam int FB_OFFSET   = 4096;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int KEY_DEPTH   = 16;
   localparam int DIM_W       = 9;
   localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT * 4;
   localparam int LANES       = 8;
   localparam int LANE_AW     = 3;
   localparam int ROWS        = STORE_BYTES / LANES;
   localparam int ROW_AW      = $clog2(ROWS);
   localparam int POS_W       = $clog2(STORE_BYTES);
   localparam int KEY_AW      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int KEY_CW      = $clog2(KEY_DEPTH + 1);

   // register offsets inside the device window
   localparam logic [31:0] REG_CONTROL    = 32'h00;
   localparam logic [31:0] REG_WIDTH      = 32'h04;
   localparam logic [31:0] REG_HEIGHT     = 32'h08;
   localparam logic [31:0] REG_PITCH      = 32'h0c;
   localparam logic [31:0] REG_STATUS     = 32'h10;
   localparam logic [31:0] REG_KEY_DATA   = 32'h20;
   localparam logic [31:0] REG_KEY_STATUS = 32'h24;
   localparam logic [31:0] REG_LAST_KEY   = 32'h28;

   localparam int CTRL_PRESENT_BIT = 0;

   // configuration register index (paddr bit 2)
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      ACT_READ    = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_KEY     = 2'd2,
      ACT_PRESENT = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] address;
      logic [3:0]  size;
      logic [63:0] write_data;
      logic [31:0] key_code;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        fault;
      logic        present_was_requested;
   } rsp_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      logic        clear;
      logic [31:0] push_data;
   } key_ctl_type;

   typedef struct packed {
      logic        not_empty;
      logic [31:0] head_data;
      logic [31:0] last_key;
   } key_sts_type;

   typedef struct packed {
      logic [LANES-1:0]             we;
      logic [LANES-1:0][ROW_AW-1:0] row;
      logic [LANES-1:0][7:0]        wdata;
   } mem_req_type;

   // width or height as used: saturated to the maximum
   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int lim);
      return (int'(v) > lim) ? DIM_W'(lim) : v;
   endfunction

endpackage

// ===== sv/fbkf_frame_mem.sv =====
// Framebuffer store: eight byte-lane memories with a registered read.
// Depends on fbkf_pkg; runs the zero-fill sweep after reset.
module fbkf_frame_mem
   import fbkf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  mem_req_type           mem_req,
   output logic                  clear_busy,
   output logic [LANES-1:0][7:0] rdata
);

   logic              clear_ff;
   logic              clear_in;
   logic [ROW_AW-1:0] clear_row_ff;
   logic [ROW_AW-1:0] clear_row_in;

   logic [LANES-1:0]             eff_we;
   logic [LANES-1:0][ROW_AW-1:0] eff_row;
   logic [LANES-1:0][7:0]        eff_wdata;

   // zero-fill sweep, one row of all lanes per cycle
   always_comb begin
      clear_in     = clear_ff;
      clear_row_in = clear_row_ff;
      if (clear_ff) begin
         clear_row_in = clear_row_ff + 1'b1;
         if (clear_row_ff == ROW_AW'(ROWS - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_row_ff <= '0;
      end else begin
         clear_ff     <= clear_in;
         clear_row_ff <= clear_row_in;
      end
   end

   assign clear_busy = clear_ff;

   // sweep takes the memory ports while it runs
   always_comb begin
      eff_we    = clear_ff ? '1 : mem_req.we;
      eff_wdata = clear_ff ? '0 : mem_req.wdata;
      for (int i = 0; i < LANES; i++) begin
         eff_row[i] = clear_ff ? clear_row_ff : mem_req.row[i];
      end
   end

   // one memory per byte lane
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [7:0] bank [ROWS];
      logic [7:0] lane_rd_ff;

      always_ff @(posedge clock) begin
         if (eff_we[g]) begin
            bank[eff_row[g]] <= eff_wdata[g];
         end
         lane_rd_ff <= bank[eff_row[g]];
      end

      assign rdata[g] = lane_rd_ff;
   end

endmodule

// ===== sv/fbkf_key_fifo.sv =====
// Bounded key queue with last-key register; full queue drops new keys.
// Depends on fbkf_pkg.
module fbkf_key_fifo
   import fbkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  key_ctl_type key_ctl,
   output key_sts_type key_sts
);

   logic [31:0]       entry_ff [KEY_DEPTH];
   logic [KEY_AW-1:0] head_ff;
   logic [KEY_AW-1:0] head_in;
   logic [KEY_CW-1:0] count_ff;
   logic [KEY_CW-1:0] count_in;
   logic [31:0]       last_ff;
   logic [31:0]       last_in;
   logic [KEY_CW:0]   tail_sum;
   logic [KEY_AW-1:0] tail;
   logic              do_push;

   // tail = (head + count) mod depth
   always_comb begin
      tail_sum = (KEY_CW + 1)'(head_ff) + (KEY_CW + 1)'(count_ff);
      if (int'(tail_sum) >= KEY_DEPTH) begin
         tail_sum = tail_sum - (KEY_CW + 1)'(KEY_DEPTH);
      end
      tail = KEY_AW'(tail_sum);
   end

   assign do_push = key_ctl.push && (int'(count_ff) < KEY_DEPTH);

   // pointer, count and last-key update
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      last_in  = last_ff;
      if (key_ctl.clear) begin
         head_in  = '0;
         count_in = '0;
         last_in  = '0;
      end else if (key_ctl.push) begin
         last_in = key_ctl.push_data;
         if (do_push) begin
            count_in = count_ff + 1'b1;
         end
      end else if (key_ctl.pop && count_ff != '0) begin
         count_in = count_ff - 1'b1;
         head_in  = (int'(head_ff) == KEY_DEPTH - 1) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         last_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   // queue entries, no reset
   always_ff @(posedge clock) begin
      if (do_push && !key_ctl.clear) begin
         entry_ff[tail] <= key_ctl.push_data;
      end
   end

   assign key_sts.not_empty = (count_ff != '0);
   assign key_sts.head_data = entry_ff[head_ff];
   assign key_sts.last_key  = last_ff;

endmodule

// ===== sv/framebuffer_display_with_key_fifo.sv =====
// Display device with framebuffer and key queue. It takes one command per cycle
// (start while busy is low) and answers each with one result on rsp_item, marked
// by rsp_strobe for a single cycle, in the cycle after acceptance; the receiver
// cannot stall, so results must be taken as they come. The result timing is set
// by the registered read of the eight byte-lane framebuffer memories. After reset
// busy stays high while the framebuffer is zero-filled, one 8-byte row per cycle;
// configuration writes are taken then.
// Depends on fbkf_pkg, fbkf_frame_mem and fbkf_key_fifo.
module framebuffer_display_with_key_fifo
   import fbkf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   input  req_type     req_item,
   output logic        busy,
   // result channel
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [DIM_W-1:0] cfg_width_ff;
   logic [DIM_W-1:0] cfg_height_ff;
   logic             dirty_ff;
   logic             dirty_in;
   logic             present_ff;
   logic             present_in;

   logic             rsp_strobe_ff;
   logic             rsp_fault_ff;
   logic             rsp_fault_in;
   logic             rsp_req_ff;
   logic             rsp_req_in;
   logic [63:0]      reg_data_ff;
   logic [63:0]      reg_data_in;
   logic             fb_rd_ff;
   logic             fb_rd_in;
   logic [LANE_AW-1:0] rd_lo_ff;
   logic [3:0]       rd_size_ff;

   logic             accept;
   logic             clear_busy;
   logic             csr_write;
   logic [DIM_W-1:0] used_w;
   logic [DIM_W-1:0] used_h;
   logic             ready;
   logic [2*DIM_W-1:0] area;
   logic [32:0]      mapped;
   logic [32:0]      end_addr;
   logic             bad_access;
   logic             fb_hit;
   logic [POS_W-1:0] pos;
   logic [ROW_AW-1:0]  base_row;
   logic [LANE_AW-1:0] lo;
   logic [LANE_AW-1:0] lane_idx;
   logic [63:0]      wshift;
   logic [63:0]      fb_data;
   logic [LANE_AW-1:0] src_lane;

   mem_req_type           mem_req;
   logic [LANES-1:0][7:0] mem_rdata;
   key_ctl_type           key_ctl;
   key_sts_type           key_sts;

   assign accept    = start && !busy;
   assign busy      = clear_busy;
   assign csr_write = psel && penable && pwrite && pready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= DIM_W'(MAX_WIDTH);
         cfg_height_ff <= DIM_W'(MAX_HEIGHT);
      end else if (csr_write) begin
         if (paddr[2] == CSR_HEIGHT) begin
            cfg_height_ff <= pwdata[DIM_W-1:0];
         end else begin
            cfg_width_ff <= pwdata[DIM_W-1:0];
         end
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_HEIGHT) ? 32'(cfg_height_ff) : 32'(cfg_width_ff);

   // window size and access check
   always_comb begin
      used_w     = sat_dim(cfg_width_ff, MAX_WIDTH);
      used_h     = sat_dim(cfg_height_ff, MAX_HEIGHT);
      ready      = (used_w != '0) && (used_h != '0);
      area       = used_w * used_h;
      mapped     = 33'(FB_OFFSET) + 33'({area, 2'b00});
      end_addr   = {1'b0, req_item.address} + 33'(req_item.size);
      bad_access = (req_item.size == 4'd0) || (req_item.size > 4'd8) || (end_addr > mapped);
      fb_hit     = accept && !bad_access && (req_item.address >= 32'(FB_OFFSET))
                   && (req_item.action == ACT_READ || req_item.action == ACT_WRITE);
   end

   // byte-lane addressing for the framebuffer
   always_comb begin
      pos      = POS_W'(req_item.address - 32'(FB_OFFSET));
      base_row = pos[POS_W-1:LANE_AW];
      lo       = pos[LANE_AW-1:0];
      for (int g = 0; g < LANES; g++) begin
         lane_idx          = LANE_AW'(g) - lo;
         wshift            = req_item.write_data >> {lane_idx, 3'b000};
         mem_req.row[g]    = base_row + ROW_AW'(LANE_AW'(g) < lo);
         mem_req.wdata[g]  = wshift[7:0];
         mem_req.we[g]     = fb_hit && (req_item.action == ACT_WRITE)
                             && ({1'b0, lane_idx} < req_item.size);
      end
   end

   // command decode: registers, key queue, present
   always_comb begin
      dirty_in          = dirty_ff;
      present_in        = present_ff;
      rsp_fault_in      = 1'b0;
      rsp_req_in        = 1'b0;
      reg_data_in       = '0;
      fb_rd_in          = 1'b0;
      key_ctl.push      = 1'b0;
      key_ctl.pop       = 1'b0;
      key_ctl.clear     = 1'b0;
      key_ctl.push_data = req_item.key_code;
      if (accept) begin
         case (req_item.action)
            ACT_KEY: begin
               key_ctl.push = 1'b1;
            end
            ACT_PRESENT: begin
               rsp_req_in = present_ff;
               present_in = 1'b0;
               if (ready) begin
                  dirty_in = 1'b0;
               end
            end
            default: begin
               if (bad_access) begin
                  rsp_fault_in = 1'b1;
               end else if (fb_hit) begin
                  if (req_item.action == ACT_WRITE) begin
                     dirty_in = 1'b1;
                  end else begin
                     fb_rd_in = 1'b1;
                  end
               end else if (req_item.action == ACT_READ) begin
                  case (req_item.address)
                     REG_KEY_DATA: begin
                        key_ctl.pop = key_sts.not_empty;
                        reg_data_in = key_sts.not_empty ? 64'(key_sts.head_data) : '0;
                     end
                     REG_KEY_STATUS: reg_data_in = 64'(key_sts.not_empty);
                     REG_LAST_KEY:   reg_data_in = 64'(key_sts.last_key);
                     REG_WIDTH:      reg_data_in = 64'(used_w);
                     REG_HEIGHT:     reg_data_in = 64'(used_h);
                     REG_PITCH:      reg_data_in = 64'({used_w, 2'b00});
                     REG_STATUS:     reg_data_in = 64'({dirty_ff, ready});
                     default:        rsp_fault_in = 1'b1;
                  endcase
               end else begin
                  case (req_item.address)
                     REG_CONTROL: begin
                        if (req_item.write_data[CTRL_PRESENT_BIT]) begin
                           present_in = 1'b1;
                        end
                     end
                     REG_KEY_STATUS: key_ctl.clear = 1'b1;
                     default:        rsp_fault_in = 1'b1;
                  endcase
               end
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff      <= 1'b1;
         present_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         fb_rd_ff      <= 1'b0;
      end else begin
         dirty_ff      <= dirty_in;
         present_ff    <= present_in;
         rsp_strobe_ff <= accept;
         fb_rd_ff      <= fb_rd_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_fault_ff <= rsp_fault_in;
      rsp_req_ff   <= rsp_req_in;
      reg_data_ff  <= reg_data_in;
      rd_lo_ff     <= lo;
      rd_size_ff   <= req_item.size;
   end

   // reassemble framebuffer bytes, little-endian from the first lane
   always_comb begin
      fb_data = '0;
      for (int i = 0; i < LANES; i++) begin
         src_lane = rd_lo_ff + LANE_AW'(i);
         if (4'(i) < rd_size_ff) begin
            fb_data[8*i +: 8] = mem_rdata[src_lane];
         end
      end
   end

   assign rsp_strobe                     = rsp_strobe_ff;
   assign rsp_item.read_data             = fb_rd_ff ? fb_data : reg_data_ff;
   assign rsp_item.fault                 = rsp_fault_ff;
   assign rsp_item.present_was_requested = rsp_req_ff;

   fbkf_frame_mem u_frame_mem (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .clear_busy (clear_busy),
      .rdata      (mem_rdata)
   );

   fbkf_key_fifo u_key_fifo (
      .clock   (clock),
      .reset   (reset),
      .key_ctl (key_ctl),
      .key_sts (key_sts)
   );

endmodule

// ===== sv/fbkf_checker.sv =====
// Port-level checker for the display block, bound to the top level.
// Depends on fbkf_pkg and the assertion macro header.
`include "framebuffer_display_with_key_fifo_defines.svh"

module fbkf_checker
   import fbkf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input rsp_type     rsp_item
);

   // every accepted command is answered in the next cycle
   `FBKF_CHK_NEXT(a_rsp_follows_accept, start && !busy, rsp_strobe)
   // no result without a command the cycle before
   `FBKF_CHK_NOW(a_rsp_has_cause, rsp_strobe, $past(start && !busy))
   // a faulted access returns no data
   `FBKF_CHK_NOW(a_fault_no_data, rsp_strobe && rsp_item.fault, rsp_item.read_data == 64'd0)
   // a present result never carries a fault or data
   `FBKF_CHK_NOW(a_present_clean, rsp_strobe && rsp_item.present_was_requested,
                 !rsp_item.fault && rsp_item.read_data == 64'd0)

endmodule

bind framebuffer_display_with_key_fifo fbkf_checker u_fbkf_checker (.*);
